// File: rtl/core/kaiser_bessel_window_eval_top_defines.svh
// Assertion macros for the window evaluator checker.
// No dependencies; included by the checker file.
`ifndef KAISER_BESSEL_WINDOW_EVAL_TOP_DEFINES_SVH
`define KAISER_BESSEL_WINDOW_EVAL_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define KBW_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("window evaluator check failed");

// Next-cycle implication, disabled while reset is high.
`define KBW_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("window evaluator check failed");

`endif

// File: rtl/core/kbw_pkg.sv
// Shared constants for the Kaiser-Bessel window evaluator.
// No dependencies; used by the top level and its checker.
package kbw_pkg;

   // Term counts, CSR address width and fixed-point constants of the datapath.
   localparam int          MAX_TERMS     = 31;
   localparam int          NUM_TERMS_DEF = 13;
   localparam int          CSR_ADDR_W    = 3;
   localparam logic [31:0] ONE_Q31       = 32'h8000_0000;
   localparam logic [31:0] SCALE_RESET   = 32'h4000_0000;

   // Register index of scale_recip, taken from the word address bit.
   localparam logic [0:0]  REG_SCALE_RECIP = 1'b0;

   // Taylor coefficients of the normalized Bessel function, unsigned Q0.32.
   localparam logic [31:0] KB_COEF [MAX_TERMS] = '{
      32'd49305943,  32'd486630156, 32'd1200711782, 32'd1316727810,
      32'd812223912, 32'd320653148, 32'd87908881,   32'd17706651,
      32'd2730588,   32'd332714,    32'd32838,      32'd2678,
      32'd184,       32'd11,        32'd1,          32'd0,
      32'd0,         32'd0,         32'd0,          32'd0,
      32'd0,         32'd0,         32'd0,          32'd0,
      32'd0,         32'd0,         32'd0,          32'd0,
      32'd0,         32'd0,         32'd0
   };

endpackage

// File: rtl/core/kaiser_bessel_window_eval_top.sv
// Throughput: one beat per cycle while req_stall is low; each Horner step has its own
// multiply and add stage. A one-entry skid register behind the last stage catches the
// beat on offer when the response side stalls, and the pipeline freezes once it is full;
// req_stall is that skid register's occupancy.
// Reset clears all valid bits and sets scale_recip to 1.0 (Q2.30).
// Depends on kbw_pkg.
module kaiser_bessel_window_eval_top #(
   parameter int NUM_TERMS = kbw_pkg::NUM_TERMS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic signed [31:0]              req_sample_position,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [31:0]                     rsp_window_value,
   output logic                            rsp_in_window,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [kbw_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);

   localparam int STEPS = NUM_TERMS - 1;

   // Configuration register.
   logic        csr_wr;
   logic        csr_hit;
   logic [31:0] scale_ff;
   logic [31:0] scale_in;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[kbw_pkg::CSR_ADDR_W-1 -: 1] == kbw_pkg::REG_SCALE_RECIP);
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign scale_in   = (csr_wr && csr_hit) ? csr_pwdata : scale_ff;
   assign csr_prdata = csr_hit ? scale_ff : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= kbw_pkg::SCALE_RESET;
      end else begin
         scale_ff <= scale_in;
      end
   end

   // Pipeline advance: everything moves unless the skid register holds a beat.
   logic en;
   logic skid_valid_ff, skid_valid_in;
   assign en        = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   // Stage 1: magnitude of the position.
   logic        v1_ff, v1_in;
   logic [31:0] mag_ff, mag_in;
   logic [31:0] raw;
   assign raw    = req_sample_position;
   assign v1_in  = req_valid;
   assign mag_in = raw[31] ? (~raw + 32'd1) : raw;

   // Stage 2: scaled position u in Q0.31 and the out-of-window flag.
   logic        v2_ff, v2_in;
   logic [30:0] u_ff, u_in;
   logic        out_ff, out_in;
   logic [63:0] scaled;
   assign v2_in  = v1_ff;
   assign scaled = {32'd0, mag_ff} * {32'd0, scale_ff};
   assign u_in   = scaled[45:15];
   assign out_in = |scaled[63:46];

   // Stage 3: u squared, back in Q0.31.
   logic        v3_ff, v3_in;
   logic [30:0] sq_ff, sq_in;
   logic        out3_ff, out3_in;
   logic [61:0] usq;
   assign v3_in   = v2_ff;
   assign usq     = {31'd0, u_ff} * {31'd0, u_ff};
   assign sq_in   = usq[61:31];
   assign out3_in = out_ff;

   // Stage 4: arg = 1 - u*u.
   logic        v4_ff, v4_in;
   logic [31:0] arg_ff, arg_in;
   logic        win4_ff, win4_in;
   assign v4_in   = v3_ff;
   assign arg_in  = kbw_pkg::ONE_Q31 - {1'b0, sq_ff};
   assign win4_in = !out3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff  <= mag_in;
         u_ff    <= u_in;
         out_ff  <= out_in;
         sq_ff   <= sq_in;
         out3_ff <= out3_in;
         arg_ff  <= arg_in;
         win4_ff <= win4_in;
      end
   end

   // Horner steps: a multiply stage then an add stage for each coefficient after the leading one.
   logic        mv_ff   [STEPS];
   logic        mv_in   [STEPS];
   logic [64:0] prod_ff [STEPS];
   logic [64:0] prod_in [STEPS];
   logic [31:0] marg_ff [STEPS-1];
   logic [31:0] marg_in [STEPS-1];
   logic        mwin_ff [STEPS];
   logic        mwin_in [STEPS];
   logic        av_ff   [STEPS];
   logic        av_in   [STEPS];
   logic [32:0] acc_ff  [STEPS];
   logic [32:0] acc_in  [STEPS];
   logic [31:0] aarg_ff [STEPS-1];
   logic [31:0] aarg_in [STEPS-1];
   logic        awin_ff [STEPS];
   logic        awin_in [STEPS];

   for (genvar j = 0; j < STEPS; j++) begin : g_step
      localparam int K = STEPS - 1 - j;

      // Multiply stage sources: the arg stage for the first step, else the previous add.
      if (j == 0) begin : g_first
         assign mv_in[j]   = v4_ff;
         assign mwin_in[j] = win4_ff;
         assign prod_in[j] = {1'b0, kbw_pkg::KB_COEF[NUM_TERMS-1]} * arg_ff;
      end else begin : g_next
         assign mv_in[j]   = av_ff[j-1];
         assign mwin_in[j] = awin_ff[j-1];
         assign prod_in[j] = acc_ff[j-1] * aarg_ff[j-1];
      end

      // Add stage: drop 31 fraction bits and add the next coefficient.
      assign av_in[j]   = mv_ff[j];
      assign awin_in[j] = mwin_ff[j];
      assign acc_in[j]  = prod_ff[j][63:31] + {1'b0, kbw_pkg::KB_COEF[K]};

      // The arg travels beside every step that still has a successor.
      if (j < STEPS - 1) begin : g_arg
         if (j == 0) begin : g_arg_first
            assign marg_in[j] = arg_ff;
         end else begin : g_arg_next
            assign marg_in[j] = aarg_ff[j-1];
         end
         assign aarg_in[j] = marg_ff[j];
         always_ff @(posedge clock) begin
            if (en) begin
               marg_ff[j] <= marg_in[j];
               aarg_ff[j] <= aarg_in[j];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            mv_ff[j] <= 1'b0;
            av_ff[j] <= 1'b0;
         end else if (en) begin
            mv_ff[j] <= mv_in[j];
            av_ff[j] <= av_in[j];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            prod_ff[j] <= prod_in[j];
            mwin_ff[j] <= mwin_in[j];
            acc_ff[j]  <= acc_in[j];
            awin_ff[j] <= awin_in[j];
         end
      end
   end

   // Final stage: round half up to Q1.31, saturate at one, zero outside the window.
   logic        pv_ff, pv_in;
   logic [31:0] val_ff, val_in;
   logic        pwin_ff, pwin_in;
   logic [33:0] rnd;
   logic [32:0] half;
   assign pv_in   = av_ff[STEPS-1];
   assign pwin_in = awin_ff[STEPS-1];
   assign rnd     = {1'b0, acc_ff[STEPS-1]} + 34'd1;
   assign half    = rnd[33:1];

   always_comb begin
      if (!awin_ff[STEPS-1]) begin
         val_in = 32'd0;
      end else if (half > {1'b0, kbw_pkg::ONE_Q31}) begin
         val_in = kbw_pkg::ONE_Q31;
      end else begin
         val_in = half[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else if (en) begin
         pv_ff <= pv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         val_ff  <= val_in;
         pwin_ff <= pwin_in;
      end
   end

   // Skid register: catches the last stage's beat when the response side stalls.
   logic [31:0] skid_val_ff, skid_val_in;
   logic        skid_win_ff, skid_win_in;
   assign skid_valid_in = rsp_stall && (skid_valid_ff || pv_ff);
   assign skid_val_in   = skid_valid_ff ? skid_val_ff : val_ff;
   assign skid_win_in   = skid_valid_ff ? skid_win_ff : pwin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else begin
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      skid_val_ff <= skid_val_in;
      skid_win_ff <= skid_win_in;
   end

   // Response beat comes from the skid register first, else from the last stage.
   assign rsp_valid        = skid_valid_ff || pv_ff;
   assign rsp_window_value = skid_valid_ff ? skid_val_ff : val_ff;
   assign rsp_in_window    = skid_valid_ff ? skid_win_ff : pwin_ff;

endmodule

// File: rtl/core/kbw_checker.sv
// Port-level checks for the Kaiser-Bessel window evaluator, bound to its top level.
// Depends on kbw_pkg and kaiser_bessel_window_eval_top_defines.svh.
`include "kaiser_bessel_window_eval_top_defines.svh"
module kbw_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_window_value,
   input logic        rsp_in_window
);

   // Response beat qualifiers and the whole payload of one beat.
   logic        in_beat;
   logic        out_beat;
   logic        rsp_held;
   logic [32:0] rsp_payload;
   assign in_beat     = rsp_valid && rsp_in_window;
   assign out_beat    = rsp_valid && !rsp_in_window;
   assign rsp_held    = rsp_valid && rsp_stall;
   assign rsp_payload = {rsp_window_value, rsp_in_window};

   // The window value never exceeds one.
   `KBW_ASSERT_SAME(a_value_range, clock, reset, rsp_valid, rsp_window_value <= kbw_pkg::ONE_Q31)

   // Outside the window the value is zero; inside it the constant term keeps it above zero.
   `KBW_ASSERT_SAME(a_out_zero, clock, reset, out_beat, rsp_window_value == 32'd0)
   `KBW_ASSERT_SAME(a_in_nonzero, clock, reset, in_beat, rsp_window_value != 32'd0)

   // Request stall only occurs while a response beat is offered.
   `KBW_ASSERT_SAME(a_stall_source, clock, reset, req_stall, rsp_valid)

   // A stalled response beat stays put.
   `KBW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_payload))

endmodule

bind kaiser_bessel_window_eval_top kbw_checker u_kbw_checker (.*);

// File: bench/tb_top.sv
// Self-checking bench for the Kaiser-Bessel window evaluator: random positions
// around the configured window edge, with response checks against a bit-true predictor.
// Depends on kbw_pkg and kaiser_bessel_window_eval_top.
`timescale 1ns / 100ps

module tb_top;

   // Horner length of the default build, held to the coefficient table.
   localparam int TERMS = (kbw_pkg::NUM_TERMS_DEF < 1) ? 1 :
      ((kbw_pkg::NUM_TERMS_DEF > kbw_pkg::MAX_TERMS) ? kbw_pkg::MAX_TERMS :
       kbw_pkg::NUM_TERMS_DEF);
   localparam logic [2:0]  ADDR_SCALE_RECIP = 3'd0;
   localparam logic [2:0]  ADDR_UNMAPPED    = 3'd4;
   localparam logic [63:0] Q31_ONE          = 64'h8000_0000;
   localparam int          DRAIN_CYCLES     = 2 * TERMS + 12;
   localparam int          STUCK_LIMIT      = 3000;

   typedef struct {
      logic [31:0] value;
      logic        in_win;
   } window_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_sample_position = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_window_value;
   logic        rsp_in_window;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   logic [31:0] positions_to_send[$];
   window_type  windows_due[$];
   logic [31:0] scale_copy = kbw_pkg::SCALE_RESET;
   int          send_gap_pct = 0;
   int          recv_stall_pct = 0;
   int          mismatches = 0;
   int          stuck_cycles = 0;

   kaiser_bessel_window_eval_top dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_sample_position (req_sample_position),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_window_value    (rsp_window_value),
      .rsp_in_window       (rsp_in_window),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Window value for one position under the current scale, Horner in Q1.31.
   function automatic window_type eval_window(logic [31:0] pos);
      logic [31:0] mag;
      logic [63:0] u;
      logic [63:0] arg;
      logic [63:0] acc;
      logic [63:0] val;
      window_type  w;
      mag = pos[31] ? (~pos + 32'd1) : pos;
      u = ({32'd0, mag} * {32'd0, scale_copy}) >> 15;
      if (u >= Q31_ONE) begin
         w.value = '0;
         w.in_win = 1'b0;
         return w;
      end
      arg = Q31_ONE - ((u * u) >> 31);
      acc = {32'd0, kbw_pkg::KB_COEF[TERMS-1]};
      for (int k = TERMS - 2; k >= 0; k--)
         acc = ((acc * arg) >> 31) + {32'd0, kbw_pkg::KB_COEF[k]};
      val = (acc + 64'd1) >> 1;
      if (val > Q31_ONE)
         val = Q31_ONE;
      w.value = val[31:0];
      w.in_win = 1'b1;
      return w;
   endfunction

   // Request driver: present the next position unless this cycle is a gap.
   always @(posedge clock) begin
      logic        nxt_valid;
      logic [31:0] nxt_pos;
      nxt_valid = req_valid;
      nxt_pos = req_sample_position;
      if (reset) begin
         nxt_valid = 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            windows_due.push_back(eval_window(req_sample_position));
            nxt_valid = 1'b0;
         end
         if (!nxt_valid && positions_to_send.size() != 0 &&
             $urandom_range(99) >= send_gap_pct) begin
            nxt_pos = positions_to_send.pop_front();
            nxt_valid = 1'b1;
         end
      end
      req_valid <= nxt_valid;
      req_sample_position <= nxt_pos;
   end

   // Response monitor: check each accepted beat against the oldest prediction.
   always @(posedge clock) begin
      window_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (windows_due.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected response beat, expected none, got %h %b",
                        $time, rsp_window_value, rsp_in_window);
            end else begin
               want = windows_due.pop_front();
               if (rsp_window_value !== want.value) begin
                  mismatches++;
                  $display("%0t: window_value mismatch, expected %h, got %h",
                           $time, want.value, rsp_window_value);
               end
               if (rsp_in_window !== want.in_win) begin
                  mismatches++;
                  $display("%0t: in_window mismatch, expected %b, got %b",
                           $time, want.in_win, rsp_in_window);
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Watchdog on cycles with no beat on either channel.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            stuck_cycles <= 0;
         end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end else begin
            stuck_cycles <= stuck_cycles + 1;
         end
      end
   end

   // APB write: setup then access; the register takes the data at the access edge.
   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr[2] == kbw_pkg::REG_SCALE_RECIP)
         scale_copy = data;
   endtask

   // APB read of the scale register, checked against the local copy.
   task automatic check_scale_readback();
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      csr_paddr <= ADDR_SCALE_RECIP;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== scale_copy) begin
         mismatches++;
         $display("%0t: scale_recip readback mismatch, expected %h, got %h",
                  $time, scale_copy, csr_prdata);
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Wait until every queued position has been answered, then let the pipe settle.
   task automatic drain();
      while (positions_to_send.size() != 0 || req_valid || windows_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Queue the window edge for the current scale, then random positions: most fall
   // inside or just around the window, the rest anywhere in the 32-bit range.
   task automatic queue_positions(int count);
      logic [63:0] edge_mag;
      logic [63:0] span;
      logic [63:0] mag;
      logic [31:0] pos;
      int          pick;
      if (scale_copy == 0)
         edge_mag = Q31_ONE;
      else
         edge_mag = ((64'd1 << 46) + {32'd0, scale_copy} - 64'd1) / {32'd0, scale_copy};
      if (edge_mag > Q31_ONE)
         edge_mag = Q31_ONE;
      if (edge_mag < Q31_ONE) begin
         positions_to_send.push_back(edge_mag[31:0]);
         positions_to_send.push_back(edge_mag[31:0] - 32'd1);
         positions_to_send.push_back(-edge_mag[31:0]);
         positions_to_send.push_back(-(edge_mag[31:0] - 32'd1));
      end
      span = edge_mag + (edge_mag >> 3);
      if (span > Q31_ONE)
         span = Q31_ONE;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 60) begin
            mag = $urandom_range(span[31:0], 0);
         end else if (pick < 75) begin
            mag = edge_mag + $urandom_range(128) - 64;
            if (mag > Q31_ONE)
               mag = Q31_ONE;
         end else begin
            mag = {32'd0, $urandom};
         end
         pos = mag[31:0];
         if ($urandom_range(1))
            pos = -pos;
         positions_to_send.push_back(pos);
      end
   endtask

   // Test sequence: directed positions, then scale settings from zero to full range.
   initial begin
      logic [31:0] directed [18];
      directed = '{
         32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
         32'h8000_0001, 32'h0000_FFFF, 32'h0001_0000, 32'hFFFF_0001, 32'hFFFF_0000,
         32'h0000_8000, 32'hFFFF_8000, 32'h0000_B505, 32'h0000_4000, 32'h5555_5555,
         32'hAAAA_AAAA, 32'h0000_0100, 32'hFFFF_FF00
      };
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_gap_pct = 21;
      recv_stall_pct = 46;
      check_scale_readback();
      foreach (directed[i])
         positions_to_send.push_back(directed[i]);
      queue_positions(250);
      drain();

      // A write past the last register must leave the scale untouched.
      csr_write(ADDR_UNMAPPED, 32'h1234_5678);
      check_scale_readback();
      queue_positions(50);
      drain();

      csr_write(ADDR_SCALE_RECIP, 32'h0000_0000);
      check_scale_readback();
      positions_to_send.push_back(32'h8000_0000);
      positions_to_send.push_back(32'h7FFF_FFFF);
      queue_positions(100);
      drain();

      send_gap_pct = 46;
      recv_stall_pct = 21;
      csr_write(ADDR_SCALE_RECIP, 32'hFFFF_FFFF);
      check_scale_readback();
      queue_positions(150);
      drain();

      csr_write(ADDR_SCALE_RECIP, $urandom);
      check_scale_readback();
      queue_positions(250);
      drain();

      send_gap_pct = 0;
      recv_stall_pct = 0;
      csr_write(ADDR_SCALE_RECIP, 32'h2000_0000);
      check_scale_readback();
      queue_positions(250);
      drain();

      csr_write(ADDR_SCALE_RECIP, $urandom_range(32'h8000_0000, 32'h1000_0000));
      check_scale_readback();
      queue_positions(350);
      drain();

      if (mismatches == 0 && windows_due.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
